// ===== rtl/dpa_pkg.sv =====
`default_nettype none
package dpa_pkg;

   typedef enum logic [3:0] {
      OP_AND = 4'd0,
      OP_EOR = 4'd1,
      OP_SUB = 4'd2,
      OP_RSB = 4'd3,
      OP_ADD = 4'd4,
      OP_ADC = 4'd5,
      OP_SBC = 4'd6,
      OP_RSC = 4'd7,
      OP_TST = 4'd8,
      OP_TEQ = 4'd9,
      OP_CMP = 4'd10,
      OP_CMN = 4'd11,
      OP_ORR = 4'd12,
      OP_MOV = 4'd13,
      OP_BIC = 4'd14,
      OP_MVN = 4'd15
   } op_type;

   localparam logic [1:0] SHIFT_LSL = 2'd0;
   localparam logic [1:0] SHIFT_LSR = 2'd1;
   localparam logic [1:0] SHIFT_ASR = 2'd2;
   localparam logic [1:0] SHIFT_ROR = 2'd3;

   localparam logic [1:0] OPND_ROT_IMM   = 2'd0;
   localparam logic [1:0] OPND_SHIFT_IMM = 2'd1;

   localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

   typedef struct packed {
      logic [3:0]  action;
      logic [1:0]  operand_kind;
      logic [31:0] first_value;
      logic [31:0] second_value;
      logic [7:0]  shift_register_byte;
      logic [7:0]  immediate_byte;
      logic [3:0]  rotate_amount;
      logic [4:0]  shift_immediate;
      logic [1:0]  shift_kind;
      logic [3:0]  flags_in;
      logic        set_flags;
   } req_type;

   typedef struct packed {
      logic [31:0] result_value;
      logic        writes_result;
      logic [3:0]  flags_out;
   } rsp_type;

   // after the shifter
   typedef struct packed {
      logic [3:0]  action;
      logic [31:0] op_a;
      logic [31:0] op_b;
      logic        shift_carry;
      logic [3:0]  flags_in;
      logic        set_flags;
   } opnd_type;

   // after the adder / logic unit
   typedef struct packed {
      logic [3:0]  action;
      logic [31:0] result;
      logic        carry;
      logic        overflow;
      logic [3:0]  flags_in;
      logic        set_flags;
   } alu_type;

endpackage
`default_nettype wire

// ===== rtl/dpa_shift.sv =====
`default_nettype none
module dpa_shift
   import dpa_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     load,
   input  wire logic     valid_in,
   input  wire req_type  data_in,
   output logic          valid_out,
   output opnd_type      data_out
);

   logic        valid_ff;
   logic        valid_in_d;
   opnd_type    data_ff;
   opnd_type    data_in_d;

   logic        c_flag;
   logic [31:0] rm;
   logic [7:0]  sh_amt;
   logic [32:0] lsl_w;
   logic [32:0] lsr_w;
   logic [32:0] asr_w;
   logic [63:0] ror_w;
   logic [63:0] imm_w;
   logic [31:0] imm_rot;
   logic [31:0] gen_val;
   logic        gen_carry;
   logic [31:0] b_val;
   logic        b_carry;

   assign c_flag = data_in.flags_in[1];
   assign rm     = data_in.second_value;

   assign imm_w   = {24'd0, data_in.immediate_byte, 24'd0, data_in.immediate_byte}
                    >> {data_in.rotate_amount, 1'b0};
   assign imm_rot = imm_w[31:0];

   assign sh_amt = (data_in.operand_kind == OPND_SHIFT_IMM) ?
                   {3'd0, data_in.shift_immediate} : data_in.shift_register_byte;

   // carry rides in the extra bit of the LSL, LSR and ASR shifters
   assign lsl_w = {1'b0, rm} << sh_amt;
   assign lsr_w = {rm, 1'b0} >> sh_amt;
   assign asr_w = $signed({rm, 1'b0}) >>> sh_amt;
   assign ror_w = {rm, rm} >> sh_amt[4:0];

   always_comb begin
      gen_val   = rm;
      gen_carry = c_flag;
      if (sh_amt != 8'd0) begin
         case (data_in.shift_kind)
            SHIFT_LSL: begin
               gen_val   = lsl_w[31:0];
               gen_carry = lsl_w[32];
            end
            SHIFT_LSR: begin
               gen_val   = lsr_w[32:1];
               gen_carry = lsr_w[0];
            end
            SHIFT_ASR: begin
               gen_val   = asr_w[32:1];
               gen_carry = asr_w[0];
            end
            default: begin
               gen_val   = ror_w[31:0];
               gen_carry = ror_w[31];
            end
         endcase
      end
   end

   always_comb begin
      b_val   = gen_val;
      b_carry = gen_carry;
      if (data_in.operand_kind == OPND_ROT_IMM) begin
         b_val   = imm_rot;
         b_carry = (data_in.rotate_amount != 4'd0) ? imm_rot[31] : c_flag;
      end else if (data_in.operand_kind == OPND_SHIFT_IMM &&
                   data_in.shift_immediate == 5'd0) begin
         // zero immediate encodes shift by 32 for LSR/ASR, or RRX for ROR; LSL #0 passes rm
         case (data_in.shift_kind)
            SHIFT_LSL: begin
               b_val   = rm;
               b_carry = c_flag;
            end
            SHIFT_LSR: begin
               b_val   = 32'd0;
               b_carry = rm[31];
            end
            SHIFT_ASR: begin
               b_val   = {32{rm[31]}};
               b_carry = rm[31];
            end
            default: begin
               b_val   = {c_flag, rm[31:1]};
               b_carry = rm[0];
            end
         endcase
      end
   end

   always_comb begin
      valid_in_d             = valid_ff;
      data_in_d              = data_ff;
      if (load) begin
         valid_in_d            = valid_in;
         data_in_d.action      = data_in.action;
         data_in_d.op_a        = data_in.first_value;
         data_in_d.op_b        = b_val;
         data_in_d.shift_carry = b_carry;
         data_in_d.flags_in    = data_in.flags_in;
         data_in_d.set_flags   = data_in.set_flags;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in_d;
      end
      data_ff <= data_in_d;
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule
`default_nettype wire

// ===== rtl/dpa_alu.sv =====
`default_nettype none
module dpa_alu
   import dpa_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     load,
   input  wire logic     valid_in,
   input  wire opnd_type data_in,
   output logic          valid_out,
   output alu_type       data_out
);

   logic        valid_ff;
   logic        valid_in_d;
   alu_type     data_ff;
   alu_type     data_in_d;

   logic [31:0] a;
   logic [31:0] b;
   logic        c_flag;
   logic [31:0] x;
   logic [31:0] y;
   logic        cin;
   logic        arith;
   logic [31:0] logic_res;
   logic [32:0] sum;
   logic [31:0] res;
   logic        carry;
   logic        ovf;

   assign a      = data_in.op_a;
   assign b      = data_in.op_b;
   assign c_flag = data_in.flags_in[1];

   always_comb begin
      x         = a;
      y         = b;
      cin       = 1'b0;
      arith     = 1'b1;
      logic_res = 32'd0;
      case (data_in.action)
         OP_AND, OP_TST: begin
            logic_res = a & b;
            arith     = 1'b0;
         end
         OP_EOR, OP_TEQ: begin
            logic_res = a ^ b;
            arith     = 1'b0;
         end
         OP_ORR: begin
            logic_res = a | b;
            arith     = 1'b0;
         end
         OP_MOV: begin
            logic_res = b;
            arith     = 1'b0;
         end
         OP_BIC: begin
            logic_res = a & ~b;
            arith     = 1'b0;
         end
         OP_MVN: begin
            logic_res = ~b;
            arith     = 1'b0;
         end
         OP_SUB, OP_CMP: begin
            y   = ~b;
            cin = 1'b1;
         end
         OP_RSB: begin
            x   = b;
            y   = ~a;
            cin = 1'b1;
         end
         OP_ADD, OP_CMN: begin
            cin = 1'b0;
         end
         OP_ADC: begin
            cin = c_flag;
         end
         OP_SBC: begin
            y   = ~b;
            cin = c_flag;
         end
         default: begin
            x   = b;
            y   = ~a;
            cin = c_flag;
         end
      endcase
   end

   assign sum = {1'b0, x} + {1'b0, y} + {32'd0, cin};

   always_comb begin
      if (arith) begin
         res   = sum[31:0];
         carry = sum[32];
         ovf   = |(~(x ^ y) & (x ^ sum[31:0]) & SIGN_BIT);
      end else begin
         // logical ops take C from the shifter and keep V
         res   = logic_res;
         carry = data_in.shift_carry;
         ovf   = data_in.flags_in[0];
      end
   end

   always_comb begin
      valid_in_d = valid_ff;
      data_in_d  = data_ff;
      if (load) begin
         valid_in_d         = valid_in;
         data_in_d.action   = data_in.action;
         data_in_d.result   = res;
         data_in_d.carry    = carry;
         data_in_d.overflow = ovf;
         data_in_d.flags_in = data_in.flags_in;
         data_in_d.set_flags = data_in.set_flags;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in_d;
      end
      data_ff <= data_in_d;
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule
`default_nettype wire

// ===== rtl/dpa_flag.sv =====
`default_nettype none
module dpa_flag
   import dpa_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load,
   input  wire logic    valid_in,
   input  wire alu_type data_in,
   output logic         valid_out,
   output rsp_type      data_out
);

   logic     valid_ff;
   logic     valid_in_d;
   rsp_type  data_ff;
   rsp_type  data_in_d;
   logic     neg;
   logic     zero;
   logic     writes;

   assign neg  = data_in.result[31];
   assign zero = (data_in.result == 32'd0);

   always_comb begin
      case (data_in.action)
         OP_TST, OP_TEQ, OP_CMP, OP_CMN: writes = 1'b0;
         default:                        writes = 1'b1;
      endcase
   end

   always_comb begin
      valid_in_d = valid_ff;
      data_in_d  = data_ff;
      if (load) begin
         valid_in_d              = valid_in;
         data_in_d.result_value  = data_in.result;
         data_in_d.writes_result = writes;
         data_in_d.flags_out     = data_in.set_flags ?
                                   {neg, zero, data_in.carry, data_in.overflow} :
                                   data_in.flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in_d;
      end
      data_ff <= data_in_d;
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule
`default_nettype wire

// ===== rtl/data_processing_alu_with_shifter_top.sv =====
`default_nettype none
// An accepted req beat passes the shift, ALU and flags stage registers in turn to its rsp beat.
// Throughput: one beat per cycle; each stage loads whenever it is empty or the next one
// advances, so the pipeline keeps streaming with no bubbles while rsp_stall is low.
// rsp_stall holds full stages in place and reaches req_stall once all three are full.
// Reset (synchronous, active high) clears the stage valid bits; no beat is in flight after it.
module data_processing_alu_with_shifter_top
   import dpa_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic     s1_valid;
   logic     s2_valid;
   opnd_type s1_data;
   alu_type  s2_data;
   logic     ready1;
   logic     ready2;
   logic     ready3;

   // a stage takes a new beat when empty or when its contents move on
   assign ready3    = !rsp_valid || !rsp_stall;
   assign ready2    = !s2_valid || ready3;
   assign ready1    = !s1_valid || ready2;
   assign req_stall = !ready1;

   dpa_shift u_shift (
      .clock     (clock),
      .reset     (reset),
      .load      (ready1),
      .valid_in  (req_valid),
      .data_in   (req_data),
      .valid_out (s1_valid),
      .data_out  (s1_data)
   );

   dpa_alu u_alu (
      .clock     (clock),
      .reset     (reset),
      .load      (ready2),
      .valid_in  (s1_valid),
      .data_in   (s1_data),
      .valid_out (s2_valid),
      .data_out  (s2_data)
   );

   dpa_flag u_flag (
      .clock     (clock),
      .reset     (reset),
      .load      (ready3),
      .valid_in  (s2_valid),
      .data_in   (s2_data),
      .valid_out (rsp_valid),
      .data_out  (rsp_data)
   );

`ifndef ASSERT_OFF
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_valid)
      else $error("accepted beat did not reach the shift stage");

   a_s1_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid && !ready2) |=> (s1_valid && $stable(s1_data)))
      else $error("shift stage lost its beat under stall");

   a_flags_kept: assert property (@(posedge clock) disable iff (reset)
      (s2_valid && ready3 && !s2_data.set_flags) |=>
      (rsp_data.flags_out == $past(s2_data.flags_in)))
      else $error("flags changed without set_flags");

   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      (s2_valid && ready3 && s2_data.set_flags) |=>
      (rsp_data.flags_out[2] == (rsp_data.result_value == 32'd0)))
      else $error("Z flag does not match the result");
`endif

endmodule
`default_nettype wire

// ===== tb/data_processing_alu_with_shifter_top_tb.sv =====
`timescale 1ns / 1ps

module data_processing_alu_with_shifter_top_tb;
   import dpa_pkg::*;

   localparam logic [1:0] OPND_SHIFT_REG = 2'd2;
   localparam logic [1:0] OPND_UNUSED    = 2'd3;
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 8;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   rsp_type expected_rsp[$];
   int      err_count    = 0;
   int      stall_pct    = 0;
   bit      hold_rsp_req = 1'b0;

   data_processing_alu_with_shifter_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [31:0] rotate_right(input logic [31:0] v, input int unsigned n);
      int unsigned k;
      k = n % 32;
      return (v >> k) | (v << (32 - k));
   endfunction

   // returns {carry, value}; a zero amount passes value and carry through
   function automatic logic [32:0] barrel_shift(input logic [31:0] v, input logic [1:0] kind,
                                                input int unsigned amt, input logic cin);
      logic [31:0] r;
      if (amt == 0) return {cin, v};
      case (kind)
         SHIFT_LSL: begin
            if (amt < 32) return {v[32 - amt], v << amt};
            return {(amt == 32) ? v[0] : 1'b0, 32'd0};
         end
         SHIFT_LSR: begin
            if (amt < 32) return {v[amt - 1], v >> amt};
            return {(amt == 32) ? v[31] : 1'b0, 32'd0};
         end
         SHIFT_ASR: begin
            if (amt < 32) begin
               r = $signed(v) >>> amt;
               return {v[amt - 1], r};
            end
            return {v[31], {32{v[31]}}};
         end
         default: begin
            r = rotate_right(v, amt);
            return {r[31], r};
         end
      endcase
   endfunction

   function automatic rsp_type predict_alu(input req_type r);
      logic [32:0] sh;
      logic [32:0] sum;
      logic [31:0] op_b, res, x, y;
      logic        sc, cin, nc, nv, arith;
      rsp_type     o;
      sc = r.flags_in[1];
      op_b = '0;
      case (r.operand_kind)
         OPND_ROT_IMM: begin
            op_b = rotate_right({24'd0, r.immediate_byte}, 2 * r.rotate_amount);
            if (r.rotate_amount != 0) sc = op_b[31];
         end
         OPND_SHIFT_IMM: begin
            // ROR #0 is RRX; LSR/ASR #0 encode a shift by 32
            if (r.shift_immediate == 0 && r.shift_kind == SHIFT_ROR)
               sh = {r.second_value[0], r.flags_in[1], r.second_value[31:1]};
            else if (r.shift_immediate == 0 && r.shift_kind != SHIFT_LSL)
               sh = barrel_shift(r.second_value, r.shift_kind, 32, sc);
            else
               sh = barrel_shift(r.second_value, r.shift_kind, 32'(r.shift_immediate), sc);
            {sc, op_b} = sh;
         end
         default: begin
            if (r.shift_kind == SHIFT_ROR && r.shift_register_byte != 0
                && r.shift_register_byte[4:0] == 0)
               sh = {r.second_value[31], r.second_value};
            else if (r.shift_kind == SHIFT_ROR)
               sh = barrel_shift(r.second_value, SHIFT_ROR,
                                 32'(r.shift_register_byte[4:0]), sc);
            else
               sh = barrel_shift(r.second_value, r.shift_kind,
                                 32'(r.shift_register_byte), sc);
            {sc, op_b} = sh;
         end
      endcase

      x = r.first_value;
      y = op_b;
      cin = 1'b0;
      arith = 1'b1;
      res = '0;
      case (op_type'(r.action))
         OP_AND, OP_TST: begin res = x & op_b; arith = 1'b0; end
         OP_EOR, OP_TEQ: begin res = x ^ op_b; arith = 1'b0; end
         OP_ORR:         begin res = x | op_b; arith = 1'b0; end
         OP_MOV:         begin res = op_b; arith = 1'b0; end
         OP_BIC:         begin res = x & ~op_b; arith = 1'b0; end
         OP_MVN:         begin res = ~op_b; arith = 1'b0; end
         OP_SUB, OP_CMP: begin y = ~op_b; cin = 1'b1; end
         OP_RSB:         begin x = op_b; y = ~r.first_value; cin = 1'b1; end
         OP_ADD, OP_CMN: ;
         OP_ADC:         cin = r.flags_in[1];
         OP_SBC:         begin y = ~op_b; cin = r.flags_in[1]; end
         default:        begin x = op_b; y = ~r.first_value; cin = r.flags_in[1]; end
      endcase

      nc = sc;
      nv = r.flags_in[0];
      if (arith) begin
         sum = {1'b0, x} + {1'b0, y} + {32'd0, cin};
         res = sum[31:0];
         nc = sum[32];
         nv = (x[31] == y[31]) && (res[31] != x[31]);
      end

      o.result_value = res;
      o.writes_result = !(r.action >= OP_TST && r.action <= OP_CMN);
      o.flags_out = r.set_flags ? {res[31], res == 32'd0, nc, nv} : r.flags_in;
      return o;
   endfunction

   function automatic req_type make_item(input op_type op, input logic [1:0] okind,
                                         input logic [31:0] a, input logic [31:0] rm,
                                         input logic [7:0] rsb, input logic [7:0] imm,
                                         input logic [3:0] rot, input logic [4:0] simm,
                                         input logic [1:0] skind, input logic [3:0] flags,
                                         input logic setf);
      req_type r;
      r.action = op;
      r.operand_kind = okind;
      r.first_value = a;
      r.second_value = rm;
      r.shift_register_byte = rsb;
      r.immediate_byte = imm;
      r.rotate_amount = rot;
      r.shift_immediate = simm;
      r.shift_kind = skind;
      r.flags_in = flags;
      r.set_flags = setf;
      return r;
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         4:       return 32'h0000_0001;
         default: return $urandom();
      endcase
   endfunction

   function automatic req_type random_item();
      req_type r;
      r.action = 4'($urandom_range(15));
      r.operand_kind = 2'($urandom_range(3));
      r.first_value = pick_word();
      r.second_value = pick_word();
      case ($urandom_range(5))
         0:       r.shift_register_byte = 8'd0;
         1:       r.shift_register_byte = {3'($urandom_range(1, 7)), 5'd0};
         2:       r.shift_register_byte = 8'($urandom_range(31));
         3:       r.shift_register_byte = 8'($urandom_range(31, 33));
         default: r.shift_register_byte = 8'($urandom_range(255));
      endcase
      r.immediate_byte = 8'($urandom_range(255));
      r.rotate_amount = 4'($urandom_range(15));
      r.shift_immediate = ($urandom_range(3) == 0) ? 5'd0 : 5'($urandom_range(31));
      r.shift_kind = 2'($urandom_range(3));
      r.flags_in = 4'($urandom_range(15));
      r.set_flags = 1'($urandom_range(1));
      return r;
   endfunction

   // hold the beat until the block takes it, then log what it must return
   task automatic send_beat(input req_type item);
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsp.push_back(predict_alu(item));
   endtask

   task automatic send_random(input int count, input bit bursty);
      int burst_left;
      burst_left = $urandom_range(1, 12);
      for (int i = 0; i < count; i++) begin
         send_beat(random_item());
         burst_left--;
         if (bursty && burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(1, 12);
         end
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_directed();
      stall_pct = 0;
      send_beat(make_item(OP_AND, OPND_ROT_IMM, 32'hFFFF_FFFF, 32'h0, 8'd0, 8'hFF, 4'd0,
                          5'd0, SHIFT_LSL, 4'b0010, 1'b1));
      send_beat(make_item(OP_EOR, OPND_ROT_IMM, 32'h1234_5678, 32'h0, 8'd0, 8'h80, 4'd4,
                          5'd0, SHIFT_LSL, 4'b0000, 1'b1));
      send_beat(make_item(OP_MOV, OPND_ROT_IMM, 32'h0, 32'h0, 8'd0, 8'hFF, 4'd15,
                          5'd0, SHIFT_LSL, 4'b0000, 1'b1));
      send_beat(make_item(OP_SUB, OPND_SHIFT_IMM, 32'h0, 32'h1, 8'd0, 8'd0, 4'd0,
                          5'd0, SHIFT_LSL, 4'b0010, 1'b1));
      send_beat(make_item(OP_RSB, OPND_SHIFT_IMM, 32'h5, 32'h8000_0000, 8'd0, 8'd0, 4'd0,
                          5'd0, SHIFT_LSR, 4'b0000, 1'b1));
      send_beat(make_item(OP_ADD, OPND_SHIFT_IMM, 32'h1, 32'h8000_0000, 8'd0, 8'd0, 4'd0,
                          5'd0, SHIFT_ASR, 4'b0000, 1'b1));
      send_beat(make_item(OP_ADD, OPND_SHIFT_IMM, 32'h1, 32'h7FFF_FFFF, 8'd0, 8'd0, 4'd0,
                          5'd0, SHIFT_ASR, 4'b1111, 1'b1));
      send_beat(make_item(OP_ADC, OPND_SHIFT_IMM, 32'h0, 32'h0000_0001, 8'd0, 8'd0, 4'd0,
                          5'd0, SHIFT_ROR, 4'b0010, 1'b1));
      send_beat(make_item(OP_MOV, OPND_SHIFT_IMM, 32'h0, 32'h8000_0001, 8'd0, 8'd0, 4'd0,
                          5'd31, SHIFT_LSL, 4'b0000, 1'b1));
      send_beat(make_item(OP_MOV, OPND_SHIFT_IMM, 32'h0, 32'h8000_0001, 8'd0, 8'd0, 4'd0,
                          5'd31, SHIFT_ROR, 4'b0000, 1'b1));
      send_beat(make_item(OP_SBC, OPND_SHIFT_REG, 32'h0, 32'h5, 8'd0, 8'd0, 4'd0,
                          5'd0, SHIFT_LSL, 4'b0000, 1'b1));
      send_beat(make_item(OP_RSC, OPND_SHIFT_REG, 32'h0, 32'h1, 8'd32, 8'd0, 4'd0,
                          5'd0, SHIFT_LSL, 4'b0010, 1'b1));
      send_beat(make_item(OP_TST, OPND_SHIFT_REG, 32'hFFFF_FFFF, 32'h8000_0000, 8'd32, 8'd0,
                          4'd0, 5'd0, SHIFT_LSR, 4'b0000, 1'b1));
      send_beat(make_item(OP_TEQ, OPND_SHIFT_REG, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd40, 8'd0,
                          4'd0, 5'd0, SHIFT_LSL, 4'b0010, 1'b1));
      send_beat(make_item(OP_CMP, OPND_SHIFT_REG, 32'h0, 32'h8000_0000, 8'd32, 8'd0, 4'd0,
                          5'd0, SHIFT_ASR, 4'b0000, 1'b1));
      send_beat(make_item(OP_CMN, OPND_SHIFT_REG, 32'h1, 32'hFFFF_FFFF, 8'd255, 8'd0, 4'd0,
                          5'd0, SHIFT_ASR, 4'b0000, 1'b1));
      send_beat(make_item(OP_ORR, OPND_SHIFT_REG, 32'h0, 32'h8000_0001, 8'd32, 8'd0, 4'd0,
                          5'd0, SHIFT_ROR, 4'b0000, 1'b1));
      send_beat(make_item(OP_MOV, OPND_SHIFT_REG, 32'h0, 32'h0000_0001, 8'd64, 8'd0, 4'd0,
                          5'd0, SHIFT_ROR, 4'b0000, 1'b1));
      send_beat(make_item(OP_BIC, OPND_SHIFT_REG, 32'hFFFF_FFFF, 32'h0000_00F0, 8'd36, 8'd0,
                          4'd0, 5'd0, SHIFT_ROR, 4'b0000, 1'b1));
      send_beat(make_item(OP_MVN, OPND_UNUSED, 32'h0, 32'h8000_0000, 8'd33, 8'd0, 4'd0,
                          5'd0, SHIFT_LSR, 4'b0000, 1'b1));
      send_beat(make_item(OP_ADD, OPND_SHIFT_IMM, 32'h7FFF_FFFF, 32'h1, 8'd0, 8'd0, 4'd0,
                          5'd0, SHIFT_LSL, 4'b0000, 1'b1));
      send_beat(make_item(OP_ADD, OPND_SHIFT_IMM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF,
                          4'd15, 5'd0, SHIFT_LSL, 4'b1111, 1'b1));
      send_beat(make_item(OP_SUB, OPND_SHIFT_IMM, 32'h0, 32'h1, 8'd0, 8'd0, 4'd0,
                          5'd0, SHIFT_LSL, 4'b1010, 1'b0));
      send_beat(make_item(OP_MVN, OPND_ROT_IMM, 32'h0, 32'h0, 8'd0, 8'd0, 4'd0,
                          5'd0, SHIFT_LSL, 4'b1111, 1'b0));
      wait_drained();
   endtask

   task automatic test_streaming();
      stall_pct = 0;
      send_random(600, 1'b0);
      wait_drained();
   endtask

   task automatic test_bursty();
      stall_pct = 30;
      send_random(400, 1'b1);
      wait_drained();
   endtask

   // receiver goes quiet while the sender keeps pushing, so the pipe backs up
   task automatic test_backpressure();
      stall_pct = 0;
      hold_rsp_req = 1'b1;
      send_random(100, 1'b0);
      wait_drained();
   endtask

   task automatic test_heavy_stall();
      stall_pct = 75;
      send_random(300, 1'b1);
      wait_drained();
   endtask

   task automatic flag_error(input string msg);
      err_count++;
      if (err_count <= 10) $display("%0t: mismatch: %s", $realtime, msg);
   endtask

   // receiver: stall in runs of random length, or hold off on request
   initial begin
      bit stalling;
      int run;
      stalling = 1'b0;
      run = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            hold_rsp_req = 1'b0;
            run = 0;
         end else begin
            if (run == 0) begin
               stalling = $urandom_range(99) < stall_pct;
               run = $urandom_range(1, 8);
            end
            rsp_stall <= stalling;
            run--;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            flag_error($sformatf("unexpected beat %08h/%0b/%h", rsp_data.result_value,
                                 rsp_data.writes_result, rsp_data.flags_out));
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.result_value !== want.result_value)
               flag_error($sformatf("result_value exp %08h got %08h",
                                    want.result_value, rsp_data.result_value));
            if (rsp_data.writes_result !== want.writes_result)
               flag_error($sformatf("writes_result exp %0b got %0b",
                                    want.writes_result, rsp_data.writes_result));
            if (rsp_data.flags_out !== want.flags_out)
               flag_error($sformatf("flags_out exp %04b got %04b",
                                    want.flags_out, rsp_data.flags_out));
         end
      end
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_streaming();
      test_bursty();
      test_backpressure();
      test_heavy_stall();

      if (err_count == 0 && expected_rsp.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/dpa_pkg.sv
rtl/dpa_shift.sv
rtl/dpa_alu.sv
rtl/dpa_flag.sv
rtl/data_processing_alu_with_shifter_top.sv
tb/data_processing_alu_with_shifter_top_tb.sv
